[src/crrl_pkg.sv]
`timescale 1ns / 1ps

package crrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 8;
    localparam int TIME_W            = 32;
    localparam int WAIT_W            = 16;
    localparam int COUNT_W           = 16;
    localparam int LEFT_W            = 16;
    localparam int STATUS_W          = 2;
    localparam int IN_TDATA_W        = 72;
    localparam int OUT_TDATA_W       = 40;
    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
        logic [LEN_W-1:0]   len;
        logic [ADDR_W-1:0]  addr;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic rd_en;
        logic eval;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

[src/client_request_rate_limiter_core.sv]
`timescale 1ns / 1ps

// Per-client request limiter over a table of TABLE_ENTRIES slots held in one RAM.
// The table RAM gives one entry per cycle with a registered read, so the scan reads
// every slot once and checks the last slot in the cycle after its read. That scan
// expires old entries, finds a live match and finds the lowest free slot. The commit
// state then writes the chosen slot back and loads the result. The next request is
// accepted in the cycle after the result is loaded, so a new request is not taken
// before the last one's result is loaded. A result that still waits for m_tready
// holds off the next load, and the next acceptance, until it leaves. Result status:
// 0 accepted and recorded, 1 rejected as too soon (with repeat count and seconds
// left), 2 accepted but table full. cfg_wdata sets the wait in seconds (reset 10).
// Write it only while no request is in flight. The table is empty after reset.
module client_request_rate_limiter_core #(
    parameter int TABLE_ENTRIES = crrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [crrl_pkg::WAIT_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // client_addr[31:0], addr_len[39:32], now_seconds[71:40]
    input  logic [crrl_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], repeat_count[17:2], time_left[33:18], zero[39:34]
    output logic [crrl_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    crrl_pkg::cmd_t     cmd;
    crrl_pkg::dp_stat_t stat;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   eval_idx;

    crrl_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .eval_idx (eval_idx)
    );

    crrl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .rd_idx    (rd_idx),
        .eval_idx  (eval_idx)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == crrl_pkg::ST_ACCEPT ||
                      m_tdata[1:0] == crrl_pkg::ST_REJECT ||
                      m_tdata[1:0] == crrl_pkg::ST_FULL))
        else $error("undefined result status");

    a_accept_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != crrl_pkg::ST_REJECT) |-> (m_tdata[33:2] == '0))
        else $error("accepted result carries count or wait");

    a_reject_left: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == crrl_pkg::ST_REJECT) |-> (m_tdata[33:18] != '0))
        else $error("rejected result with no time left");

endmodule

[src/crrl_ram.sv]
`timescale 1ns / 1ps

module crrl_ram #(
    parameter int WIDTH = crrl_pkg::ENTRY_W,
    parameter int DEPTH = crrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/crrl_ctrl.sv]
`timescale 1ns / 1ps

module crrl_ctrl #(
    parameter int TABLE_ENTRIES = crrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  crrl_pkg::dp_stat_t               stat,
    output crrl_pkg::cmd_t                   cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
    output logic [$clog2(TABLE_ENTRIES)-1:0] eval_idx
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  eval_idx_reg, eval_idx_next;
    logic              eval_reg, eval_next;

    always_comb
    begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        eval_idx_next = eval_idx_reg;
        eval_next     = 1'b0;
        cmd           = '0;
        cmd.eval      = eval_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load    = 1'b1;
                    rd_idx_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en     = 1'b1;
                eval_next     = 1'b1;
                eval_idx_next = rd_idx_reg;
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_idx_reg   <= '0;
            eval_idx_reg <= '0;
            eval_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            eval_idx_reg <= eval_idx_next;
            eval_reg     <= eval_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign rd_idx   = rd_idx_reg;
    assign eval_idx = eval_idx_reg;

endmodule

[src/crrl_dp.sv]
`timescale 1ns / 1ps

module crrl_dp #(
    parameter int TABLE_ENTRIES = crrl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [crrl_pkg::WAIT_W-1:0]           cfg_wdata,
    input  logic [crrl_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [crrl_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  crrl_pkg::cmd_t                        cmd,
    output crrl_pkg::dp_stat_t                    stat,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      rd_idx,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      eval_idx
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [crrl_pkg::WAIT_W-1:0]   wait_reg;
    logic [TABLE_ENTRIES-1:0]      valid_reg, valid_next;
    logic [crrl_pkg::ADDR_W-1:0]   addr_reg;
    logic [crrl_pkg::LEN_W-1:0]    len_reg;
    logic [crrl_pkg::TIME_W-1:0]   now_reg;
    logic                          hit_reg;
    logic [IDX_W-1:0]              hit_idx_reg;
    logic [crrl_pkg::COUNT_W-1:0]  hit_count_reg;
    logic [crrl_pkg::TIME_W-1:0]   hit_time_reg;
    logic [crrl_pkg::LEFT_W-1:0]   hit_left_reg;
    logic                          free_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic                          out_valid_reg;
    crrl_pkg::status_t             out_status_reg;
    logic [crrl_pkg::COUNT_W-1:0]  out_count_reg;
    logic [crrl_pkg::LEFT_W-1:0]   out_left_reg;

    logic [crrl_pkg::ENTRY_W-1:0]  rd_data;
    crrl_pkg::entry_t              ent;
    crrl_pkg::entry_t              wr_ent;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_idx;
    logic [crrl_pkg::TIME_W-1:0]   age;
    logic                          live;
    logic                          expired;
    logic                          match;
    crrl_pkg::status_t             res_status;
    logic [crrl_pkg::COUNT_W-1:0]  res_count;
    logic [crrl_pkg::LEFT_W-1:0]   res_left;

    crrl_ram #(
        .WIDTH (crrl_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_ent),
        .re    (cmd.rd_en),
        .raddr (rd_idx),
        .rdata (rd_data)
    );

    assign ent     = crrl_pkg::entry_t'(rd_data);
    assign age     = now_reg - ent.stamp;
    assign live    = valid_reg[eval_idx];
    assign expired = (age >= {{(crrl_pkg::TIME_W - crrl_pkg::WAIT_W){1'b0}}, wait_reg});
    assign match   = (ent.addr == addr_reg) && (ent.len == len_reg);

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.eval && live && expired)
        begin
            valid_next[eval_idx] = 1'b0;
        end
        if (cmd.commit && !hit_reg && free_reg)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end
    end

    always_comb
    begin
        wr_en  = cmd.commit && (hit_reg || free_reg);
        wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
        wr_ent.addr  = addr_reg;
        wr_ent.len   = len_reg;
        wr_ent.stamp = hit_reg ? hit_time_reg : now_reg;
        wr_ent.count = hit_reg ? hit_count_reg : '0;
    end

    always_comb
    begin
        res_count = '0;
        res_left  = '0;
        if (hit_reg)
        begin
            res_status = crrl_pkg::ST_REJECT;
            res_count  = hit_count_reg;
            res_left   = hit_left_reg;
        end
        else if (free_reg)
        begin
            res_status = crrl_pkg::ST_ACCEPT;
        end
        else
        begin
            res_status = crrl_pkg::ST_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg      <= crrl_pkg::WAIT_RESET;
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wait_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd.eval)
            begin
                if (live && !expired && match)
                begin
                    hit_reg <= 1'b1;
                end
                if ((!live || expired) && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= s_tdata[crrl_pkg::ADDR_W-1:0];
            len_reg  <= s_tdata[crrl_pkg::ADDR_W +: crrl_pkg::LEN_W];
            now_reg  <= s_tdata[crrl_pkg::ADDR_W + crrl_pkg::LEN_W +: crrl_pkg::TIME_W];
        end
        if (cmd.eval && live && !expired && match && !hit_reg)
        begin
            hit_idx_reg   <= eval_idx;
            hit_time_reg  <= ent.stamp;
            hit_count_reg <= (ent.count == crrl_pkg::COUNT_MAX) ? ent.count
                                                                : ent.count + 16'd1;
            hit_left_reg  <= wait_reg - age[crrl_pkg::LEFT_W-1:0];
        end
        if (cmd.eval && (!live || expired) && !free_reg)
        begin
            free_idx_reg <= eval_idx;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status;
            out_count_reg  <= res_count;
            out_left_reg   <= res_left;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {6'b0, out_left_reg, out_count_reg, out_status_reg};

endmodule
